FILE: rtl/utt_pkg.sv
// Package of the UTF-8 to UTF-16 transcoder: item types, decode result type,
// constants and byte classification functions.
// No dependencies; imported by every other file of the block but utt_stream_if.
`default_nettype none

package utt_pkg;

    localparam int MAX_UNITS  = 4;
    localparam int UNIT_IDX_W = 2;
    localparam int UNIT_CNT_W = 3;
    localparam int HELD_DEPTH = 3;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [15:0] SPACE_UNIT  = 16'h0020;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [7:0]  MIN_LEAD2   = 8'hC2;
    localparam logic [7:0]  MAX_LEAD4   = 8'hF4;
    localparam logic [4:0]  SURR_PREFIX = 5'b11011;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } utf8_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        out_last;
    } utf16_item_t;

    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [UNIT_CNT_W-1:0]      n_units;
        logic                       last;
    } decode_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        if (b[7] == 1'b0)
            n = 3'd1;
        else if (b[7:5] == 3'b110)
            n = 3'd2;
        else if (b[7:4] == 4'b1110)
            n = 3'd3;
        else if (b[7:3] == 5'b11110)
            n = 3'd4;
        else
            n = 3'd0;
        return n;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/utt_stream_if.sv
// Valid/ready stream channel of the transcoder, one item per handshake.
// Payload type is a parameter; the item types come from utt_pkg.
`default_nettype none

interface utt_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/utt_decoder.sv
// Held-byte registers and single-pass decode of held bytes plus the new byte.
// Depends on utt_pkg for types, constants and byte classification.
`default_nettype none

module utt_decoder
    import utt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire utf8_item_t item,
    input  wire logic       accept,
    output decode_t         result
);

    logic [HELD_DEPTH-1:0][7:0] held_bytes_reg, held_bytes_next;
    logic [1:0]                 held_count_reg, held_count_next;
    logic [2:0]                 exp_len_reg, exp_len_next;

    always_comb
    begin
        logic [7:0]            bb [7];
        logic [2:0]            len;
        logic [2:0]            pos;
        logic                  stop;
        logic [UNIT_CNT_W-1:0] n;
        logic [7:0]            lead;
        logic [2:0]            need;
        logic                  ok;
        logic [20:0]           cp;
        logic [19:0]           v;
        logic [2:0]            idx;

        for (int j = 0; j < 7; j++)
            bb[j] = 8'h00;
        for (int j = 0; j < HELD_DEPTH; j++)
            if (2'(j) < held_count_reg)
                bb[j] = held_bytes_reg[j];
        bb[held_count_reg] = item.in_byte;
        len = {1'b0, held_count_reg} + 3'd1;

        pos    = 3'd0;
        stop   = 1'b0;
        n      = '0;
        result.units = '0;
        lead = 8'h00;
        need = 3'd0;
        ok   = 1'b0;
        cp   = '0;
        v    = '0;

        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < len && 3'(i) == pos && !stop)
            begin
                lead = bb[i];
                need = (i == 0 && held_count_reg != 2'd0) ? exp_len_reg : lead_length(lead);
                if (lead == 8'h00)
                begin
                    result.units[n[UNIT_IDX_W-1:0]] = SPACE_UNIT;
                    n   = n + 1'b1;
                    pos = pos + 3'd1;
                end
                else if (need == 3'd0)
                begin
                    result.units[n[UNIT_IDX_W-1:0]] = REPL_UNIT;
                    n   = n + 1'b1;
                    pos = pos + 3'd1;
                end
                else if (4'(i) + {1'b0, need} > {1'b0, len})
                begin
                    if (item.in_last)
                    begin
                        result.units[n[UNIT_IDX_W-1:0]] = REPL_UNIT;
                        n = n + 1'b1;
                    end
                    stop = 1'b1;
                end
                else
                begin
                    ok = 1'b1;
                    for (int k = 1; k < 4; k++)
                        if (3'(k) < need && !is_cont(bb[i+k]))
                            ok = 1'b0;
                    if (need == 3'd2 && lead < MIN_LEAD2)
                        ok = 1'b0;
                    if (need == 3'd4 && lead > MAX_LEAD4)
                        ok = 1'b0;
                    if (!ok)
                    begin
                        result.units[n[UNIT_IDX_W-1:0]] = REPL_UNIT;
                        n   = n + 1'b1;
                        pos = pos + 3'd1;
                    end
                    else
                    begin
                        case (need)
                            3'd1:    cp = {13'b0, lead};
                            3'd2:    cp = {10'b0, lead[4:0], bb[i+1][5:0]};
                            3'd3:    cp = {5'b0, lead[3:0], bb[i+1][5:0], bb[i+2][5:0]};
                            default: cp = {lead[2:0], bb[i+1][5:0], bb[i+2][5:0],
                                           bb[i+3][5:0]};
                        endcase
                        if (cp[20:16] == 5'd0)
                        begin
                            result.units[n[UNIT_IDX_W-1:0]] =
                                (cp[15:11] == SURR_PREFIX) ? REPL_UNIT : cp[15:0];
                            n = n + 1'b1;
                        end
                        else if (cp <= CP_MAX)
                        begin
                            v = 20'(cp - SUPP_BASE);
                            result.units[n[UNIT_IDX_W-1:0]] = HI_SURR | {6'b0, v[19:10]};
                            n = n + 1'b1;
                            result.units[n[UNIT_IDX_W-1:0]] = LO_SURR | {6'b0, v[9:0]};
                            n = n + 1'b1;
                        end
                        else
                        begin
                            result.units[n[UNIT_IDX_W-1:0]] = REPL_UNIT;
                            n = n + 1'b1;
                        end
                        pos = pos + need;
                    end
                end
            end
        end

        result.n_units = n;
        result.last    = item.in_last;

        for (int k = 0; k < HELD_DEPTH; k++)
        begin
            idx = pos + 3'(k);
            held_bytes_next[k] = bb[idx];
        end
        if (stop && !item.in_last)
        begin
            held_count_next = 2'(len - pos);
            exp_len_next    = lead_length(bb[pos]);
        end
        else
        begin
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            exp_len_reg    <= 3'd0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_bytes_reg <= held_bytes_next;
    end

endmodule

`default_nettype wire

FILE: rtl/utt_unit_queue.sv
// Result register of the transcoder: holds the code units of one item and
// hands them out one per handshake. Depends on utt_pkg and utt_stream_if.
`default_nettype none

module utt_unit_queue
    import utt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire decode_t  result,
    input  wire logic     load,
    output logic          can_load,
    utt_stream_if.source  utf16
);

    logic [MAX_UNITS-1:0][15:0] units_reg;
    logic [UNIT_CNT_W-1:0]      count_reg;
    logic [UNIT_IDX_W-1:0]      idx_reg;
    logic                       last_reg;
    logic                       take;

    assign take     = utf16.valid && utf16.ready;
    assign can_load = (count_reg == '0) || (count_reg == UNIT_CNT_W'(1) && utf16.ready);

    assign utf16.valid             = count_reg != '0;
    assign utf16.payload.code_unit = units_reg[idx_reg];
    assign utf16.payload.out_last  = last_reg && count_reg == UNIT_CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            count_reg <= result.n_units;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            count_reg <= count_reg - 1'b1;
            idx_reg   <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            units_reg <= result.units;
            last_reg  <= result.last;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/utf8_to_utf16_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16 transcoder: decoder and result register.
// Depends on utt_pkg, utt_stream_if, utt_decoder and utt_unit_queue.
//
// Takes one UTF-8 byte per item and gives UTF-16 code units, one per item on
// the output channel, the final unit of a string marked by out_last. Each
// accepted byte is decoded in the same cycle against the held bytes of an
// unfinished sequence; its code units (none to four) are registered and
// appear from the next cycle on. A byte is accepted whenever the result
// register is empty or its final unit leaves in that cycle, so the input
// side waits while the output drains the units one per cycle while
// utf16.ready stays high. Sequences with a bad lead or continuation byte
// or an overlong two-byte form, truncated sequences, surrogate and
// out-of-range code points yield U+FFFD; a zero byte yields a space.
`default_nettype none

module utf8_to_utf16_transcoder_unit
    import utt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    utt_stream_if.sink   utf8,
    utt_stream_if.source utf16
);

    decode_t    result;
    logic       can_load;
    logic       accept;
    utf8_item_t item;

    assign item       = utf8.payload;
    assign utf8.ready = can_load;
    assign accept     = utf8.valid && can_load;

    utt_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .accept (accept),
        .result (result)
    );

    utt_unit_queue u_unit_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .load     (accept),
        .can_load (can_load),
        .utf16    (utf16)
    );

endmodule

`default_nettype wire

FILE: dv/utt_transcoder_checker.sv
// Checker of the UTF-8 to UTF-16 transcoder: watches both channels, keeps its own
// decoder of the byte stream and compares every code unit that leaves the block.
// Depends on utt_pkg for the item types and the code unit constants.
`default_nettype none

module utt_transcoder_checker
    import utt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        utf8_valid,
    input  wire logic        utf8_ready,
    input  wire utf8_item_t  utf8_item,
    input  wire logic        utf16_valid,
    input  wire logic        utf16_ready,
    input  wire utf16_item_t utf16_item,
    output int               units_due,
    output int               mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  held_seq [3];
    int          held_n;
    utf16_item_t due_units [$];

    function automatic void transcode_byte(input logic [7:0] b, input logic lst);
        logic [7:0]  seq [4];
        logic [15:0] fresh [$];
        logic [7:0]  lead;
        logic [20:0] cp;
        logic [19:0] off;
        logic        ok;
        int          len;
        int          pos;
        int          span;
        int          k;
        utf16_item_t unit;
        for (k = 0; k < held_n; k++)
            seq[k] = held_seq[k];
        seq[held_n] = b;
        len = held_n + 1;
        pos = 0;
        while (pos < len)
        begin
            lead = seq[pos];
            casez (lead)
                8'b0???????: span = 1;
                8'b110?????: span = 2;
                8'b1110????: span = 3;
                8'b11110???: span = 4;
                default:     span = 0;
            endcase
            if (lead == 8'h00)
            begin
                fresh.insert(fresh.size(), SPACE_UNIT);
                pos++;
            end
            else if (span == 0)
            begin
                fresh.insert(fresh.size(), REPL_UNIT);
                pos++;
            end
            else if (pos + span > len)
            begin
                // sequence still open; at end of string it collapses to one replacement
                if (lst)
                begin
                    fresh.insert(fresh.size(), REPL_UNIT);
                    pos = len;
                end
                break;
            end
            else
            begin
                ok = 1'b1;
                for (k = 1; k < span; k++)
                    if (seq[pos + k][7:6] != 2'b10)
                        ok = 1'b0;
                if (span == 2 && lead < MIN_LEAD2)
                    ok = 1'b0;
                if (span == 4 && lead > MAX_LEAD4)
                    ok = 1'b0;
                if (!ok)
                begin
                    // replace the lead only and rescan what follows it
                    fresh.insert(fresh.size(), REPL_UNIT);
                    pos++;
                end
                else
                begin
                    case (span)
                        1: cp = {13'd0, lead};
                        2: cp = {10'd0, lead[4:0], seq[pos + 1][5:0]};
                        3: cp = {5'd0, lead[3:0], seq[pos + 1][5:0], seq[pos + 2][5:0]};
                        default: cp = {lead[2:0], seq[pos + 1][5:0], seq[pos + 2][5:0],
                                       seq[pos + 3][5:0]};
                    endcase
                    if (cp > CP_MAX)
                        fresh.insert(fresh.size(), REPL_UNIT);
                    else if (cp >= SUPP_BASE)
                    begin
                        off = 20'(cp - SUPP_BASE);
                        fresh.insert(fresh.size(), HI_SURR + 16'(off[19:10]));
                        fresh.insert(fresh.size(), LO_SURR + 16'(off[9:0]));
                    end
                    else if (cp[15:11] == SURR_PREFIX)
                        fresh.insert(fresh.size(), REPL_UNIT);
                    else
                        fresh.insert(fresh.size(), cp[15:0]);
                    pos += span;
                end
            end
        end
        held_n = 0;
        if (!lst)
        begin
            while (pos < len)
            begin
                held_seq[held_n] = seq[pos];
                held_n++;
                pos++;
            end
        end
        foreach (fresh[i])
        begin
            unit.code_unit = fresh[i];
            unit.out_last  = lst && (i == fresh.size() - 1);
            due_units.insert(due_units.size(), unit);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        utf16_item_t want;
        if (!rst_n)
        begin
            held_n = 0;
            due_units.delete();
            units_due <= 0;
        end
        else
        begin
            if (utf16_valid && utf16_ready)
            begin
                if (due_units.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected unit %h last %b", utf16_item.code_unit,
                                 utf16_item.out_last);
                    mismatches++;
                end
                else
                begin
                    want = due_units.pop_front();
                    if (want.code_unit != utf16_item.code_unit ||
                        want.out_last != utf16_item.out_last)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: unit %h last %b, expected unit %h last %b",
                                     utf16_item.code_unit, utf16_item.out_last,
                                     want.code_unit, want.out_last);
                        mismatches++;
                    end
                end
            end
            if (utf8_valid && utf8_ready)
                transcode_byte(utf8_item.in_byte, utf8_item.in_last);
            units_due <= due_units.size();
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb_utf8_to_utf16_transcoder_unit.sv
// Testbench top of the UTF-8 to UTF-16 transcoder: clock, reset, byte stimulus,
// random back-pressure, watchdog and verdict.
// Depends on utt_pkg, utt_stream_if, the block and utt_transcoder_checker.
`default_nettype none

module tb_utf8_to_utf16_transcoder_unit;
    import utt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 400;
    localparam int STALL_LIMIT  = 1000;

    localparam logic [8:0] OPENING_BYTES [32] = '{
        9'h000, 9'h07F, 9'h0C3, 9'h0A9, 9'h0C0, 9'h1AF,
        9'h0E2, 9'h082, 9'h0AC, 9'h0ED, 9'h0A0, 9'h080, 9'h0E0, 9'h080, 9'h180,
        9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0F4, 9'h090, 9'h080, 9'h180,
        9'h0E2, 9'h041, 9'h0FF, 9'h0F5, 9'h080, 9'h080, 9'h180,
        9'h0F0, 9'h19F
    };

    logic clk;
    logic rst_n;
    logic steady;
    int   units_due;
    int   mismatches;
    int   quiet_cycles;

    utt_stream_if #(.payload_t(utf8_item_t))  utf8_ch ();
    utt_stream_if #(.payload_t(utf16_item_t)) utf16_ch ();

    utf8_to_utf16_transcoder_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8_ch),
        .utf16 (utf16_ch)
    );

    utt_transcoder_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .utf8_valid  (utf8_ch.valid),
        .utf8_ready  (utf8_ch.ready),
        .utf8_item   (utf8_ch.payload),
        .utf16_valid (utf16_ch.valid),
        .utf16_ready (utf16_ch.ready),
        .utf16_item  (utf16_ch.payload),
        .units_due   (units_due),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        utf16_ch.ready <= steady || ($urandom_range(0, 99) >= 38);

    always @(posedge clk)
    begin
        if (!rst_n || (utf8_ch.valid && utf8_ch.ready) || (utf16_ch.valid && utf16_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_byte(input logic [7:0] b, input logic lst);
        while (!steady && $urandom_range(0, 99) < 38)
        begin
            utf8_ch.valid <= 1'b0;
            @(posedge clk);
        end
        utf8_ch.valid   <= 1'b1;
        utf8_ch.payload <= '{in_byte: b, in_last: lst};
        do
            @(posedge clk);
        while (!utf8_ch.ready);
    endtask

    initial
    begin
        int         sent;
        int         nb;
        int         kind;
        int         chars;
        logic       paused;
        logic [20:0] cp;
        logic [7:0] enc [4];
        logic [7:0] text [$];
        sent   = 0;
        paused = 1'b0;
        steady          <= 1'b0;
        rst_n           <= 1'b0;
        utf8_ch.valid   <= 1'b0;
        utf8_ch.payload <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING_BYTES[i])
            push_byte(OPENING_BYTES[i][7:0], OPENING_BYTES[i][8]);

        while (sent < RANDOM_ITEMS)
        begin
            text.delete();
            chars = $urandom_range(1, 8);
            for (int c = 0; c < chars; c++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 30)
                begin
                    enc[0] = 8'($urandom_range(0, 127));
                    nb = 1;
                end
                else if (kind < 50)
                begin
                    cp = 21'($urandom_range(32'h80, 32'h7FF));
                    enc[0] = {3'b110, cp[10:6]};
                    enc[1] = {2'b10, cp[5:0]};
                    nb = 2;
                end
                else if (kind < 70)
                begin
                    case ($urandom_range(0, 9))
                        0: cp = 21'($urandom_range(32'hD800, 32'hDFFF));
                        1: cp = 21'($urandom_range(32'h0, 32'h7FF));
                        default: cp = 21'($urandom_range(32'h800, 32'hFFFF));
                    endcase
                    enc[0] = {4'b1110, cp[15:12]};
                    enc[1] = {2'b10, cp[11:6]};
                    enc[2] = {2'b10, cp[5:0]};
                    nb = 3;
                end
                else if (kind < 85)
                begin
                    if ($urandom_range(0, 7) == 0)
                        cp = 21'($urandom_range(32'h110000, 32'h1FFFFF));
                    else
                        cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
                    enc[0] = {5'b11110, cp[20:18]};
                    enc[1] = {2'b10, cp[17:12]};
                    enc[2] = {2'b10, cp[11:6]};
                    enc[3] = {2'b10, cp[5:0]};
                    nb = 4;
                end
                else
                begin
                    nb = $urandom_range(1, 3);
                    for (int k = 0; k < nb; k++)
                        enc[k] = 8'($urandom_range(0, 255));
                end
                // cut the sequence short now and then
                if (nb > 1 && $urandom_range(0, 11) == 0)
                    nb = $urandom_range(1, nb - 1);
                for (int k = 0; k < nb; k++)
                    text.insert(text.size(), enc[k]);
            end
            steady <= (sent >= 150 && sent < 230);
            foreach (text[i])
                push_byte(text[i], i == text.size() - 1);
            sent += text.size();
            if (!paused && sent >= 300)
            begin
                // hold the sender until every unit has drained
                paused = 1'b1;
                utf8_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (units_due != 0);
            end
        end

        utf8_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (units_due != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
